>>> src/plist_pkg.sv
`default_nettype none
package plist_pkg;

  localparam int CAPACITY = 16;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_DELETE = 2'd1;
  localparam mode_t MODE_GET    = 2'd2;
  localparam mode_t MODE_LOCATE = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BADPOS   = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic latch;
    logic exec;
    logic load;
  } cmd_t;

endpackage
`default_nettype wire

>>> src/plist_if.sv
`default_nettype none
interface plist_in_if;
  logic                valid;
  logic                ready;
  plist_pkg::mode_t    mode;
  logic [4:0]          position;
  logic signed [31:0]  item_value;

  modport source (output valid, output mode, output position, output item_value,
                  input ready);
  modport sink (input valid, input mode, input position, input item_value,
                output ready);
endinterface

interface plist_out_if;
  logic                valid;
  logic                ready;
  plist_pkg::status_t  status;
  logic signed [31:0]  read_value;
  logic [4:0]          found_position;
  logic [4:0]          list_length;

  modport source (output valid, output status, output read_value,
                  output found_position, output list_length, input ready);
  modport sink (input valid, input status, input read_value,
                input found_position, input list_length, output ready);
endinterface
`default_nettype wire

>>> src/plist_ctrl.sv
`default_nettype none
module plist_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output plist_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load, accept;

  assign load      = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == S_IDLE) || load;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign cmd.latch = accept;
  assign cmd.exec  = (state_r == S_EXEC);
  assign cmd.load  = load;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (load) state_nxt = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/plist_dp.sv
`default_nettype none
module plist_dp #(
  parameter int CAPACITY = plist_pkg::CAPACITY,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int PW = ((CW > 5) ? CW : 5) + 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire plist_pkg::cmd_t    cmd,
  input  wire plist_pkg::mode_t   in_mode,
  input  wire logic [4:0]         in_position,
  input  wire logic [31:0]        in_item_value,
  output plist_pkg::status_t      out_status,
  output logic [31:0]             out_read_value,
  output logic [4:0]              out_found_position,
  output logic [4:0]              out_list_length,
  output logic [CW-1:0]           count
);

  plist_pkg::mode_t   mode_r;
  logic [4:0]         pos_r;
  logic [31:0]        val_r;

  logic [31:0]        cells_r   [CAPACITY];
  logic [31:0]        cells_nxt [CAPACITY];
  logic [31:0]        below     [CAPACITY];
  logic [31:0]        above     [CAPACITY];
  logic [CW-1:0]      count_r, count_nxt;

  logic [CAPACITY-1:0] hit_x, hit_r;
  logic [31:0]         rd_x, rd_r;
  plist_pkg::status_t  st_x, st_r;
  logic                loc_r;

  plist_pkg::status_t  st_f;
  logic [4:0]          found_f;
  logic                any_f;

  plist_pkg::status_t  out_status_r;
  logic [31:0]         out_rd_r;
  logic [4:0]          out_found_r;
  logic [4:0]          out_len_r;

  logic [PW-1:0] pos_e, cnt_e;
  logic          is_ins, is_del, is_get;
  logic          ins_bad, ins_full, ins_ok, rd_ok, del_ok;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_nbr
      if (g == 0) begin : g_first
        assign below[g] = cells_r[g];
      end else begin : g_mid
        assign below[g] = cells_r[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign above[g] = cells_r[g];
      end else begin : g_up
        assign above[g] = cells_r[g+1];
      end
    end
  endgenerate

  assign pos_e    = PW'(pos_r);
  assign cnt_e    = PW'(count_r);
  assign is_ins   = (mode_r == plist_pkg::MODE_INSERT);
  assign is_del   = (mode_r == plist_pkg::MODE_DELETE);
  assign is_get   = (mode_r == plist_pkg::MODE_GET);
  assign ins_bad  = (pos_e == '0) || (pos_e > cnt_e + PW'(1));
  assign ins_full = (cnt_e >= PW'(CAPACITY));
  assign ins_ok   = is_ins && !ins_bad && !ins_full;
  assign rd_ok    = (pos_e != '0) && (pos_e <= cnt_e);
  assign del_ok   = is_del && rd_ok;

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      cells_nxt[k] = cells_r[k];
      if (cmd.exec && ins_ok) begin
        if (pos_e == PW'(k + 1)) begin
          cells_nxt[k] = val_r;
        end else if (pos_e <= PW'(k)) begin
          cells_nxt[k] = below[k];
        end
      end else if (cmd.exec && del_ok) begin
        if (pos_e <= PW'(k + 1)) begin
          cells_nxt[k] = above[k];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.exec && ins_ok) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (cmd.exec && del_ok) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_comb begin
    rd_x  = '0;
    hit_x = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if ((is_del || is_get) && rd_ok && (pos_e == PW'(k + 1))) begin
        rd_x = cells_r[k];
      end
      hit_x[k] = (PW'(k) < cnt_e) && (cells_r[k] == val_r);
    end
  end

  always_comb begin
    st_x = plist_pkg::ST_OK;
    case (mode_r)
      plist_pkg::MODE_INSERT: begin
        if (ins_bad) begin
          st_x = plist_pkg::ST_BADPOS;
        end else if (ins_full) begin
          st_x = plist_pkg::ST_FULL;
        end
      end
      plist_pkg::MODE_DELETE, plist_pkg::MODE_GET: begin
        if (!rd_ok) st_x = plist_pkg::ST_BADPOS;
      end
      default: begin
        st_x = plist_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    found_f = '0;
    any_f   = 1'b0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (hit_r[k]) begin
        found_f = 5'(k + 1);
        any_f   = 1'b1;
      end
    end
  end

  always_comb begin
    st_f = st_r;
    if (loc_r) begin
      st_f = any_f ? plist_pkg::ST_OK : plist_pkg::ST_NOTFOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
    if (cmd.latch) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      val_r  <= in_item_value;
    end
    if (cmd.exec) begin
      hit_r <= hit_x;
      rd_r  <= rd_x;
      st_r  <= st_x;
      loc_r <= (mode_r == plist_pkg::MODE_LOCATE);
    end
    if (cmd.load) begin
      out_status_r <= st_f;
      out_rd_r     <= rd_r;
      out_found_r  <= loc_r ? found_f : 5'd0;
      out_len_r    <= 5'(count_r);
    end
  end

  assign out_status         = out_status_r;
  assign out_read_value     = out_rd_r;
  assign out_found_position = out_found_r;
  assign out_list_length    = out_len_r;
  assign count              = count_r;

endmodule
`default_nettype wire

>>> src/positional_list_engine_top.sv
// Flow: an accepted request passes the execute and finish steps of the controller;
// the next one is taken as its result loads, which waits while out_chan stalls, and
// the cell array shifts or compares all entries in the execute cycle.
// Reset: rst_n is synchronous, active low; it clears the list length and the
// handshake state. Entry cells are not cleared and hold nothing until written.
`default_nettype none
module positional_list_engine_top #(
  parameter int CAPACITY = plist_pkg::CAPACITY
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  plist_in_if.sink     in_chan,
  plist_out_if.source  out_chan
);

  localparam int CW = $clog2(CAPACITY + 1);

  plist_pkg::cmd_t  cmd;
  logic [CW-1:0]    count;
  logic [31:0]      rd_w;

  plist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  plist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_mode            (in_chan.mode),
    .in_position        (in_chan.position),
    .in_item_value      (in_chan.item_value),
    .out_status         (out_chan.status),
    .out_read_value     (rd_w),
    .out_found_position (out_chan.found_position),
    .out_list_length    (out_chan.list_length),
    .count              (count)
  );

  assign out_chan.read_value = rd_w;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request accepted in back-to-back cycles");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status != plist_pkg::ST_OK)) |->
      (out_chan.read_value == 32'sd0))
    else $error("failed request returns data");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count != $past(count)) |-> $past(cmd.exec))
    else $error("list length changed outside execute");

endmodule
`default_nettype wire

>>> dv/plist_list_checker.sv
`timescale 1ns / 1ps
module plist_list_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  plist_in_if       in_mon,
  plist_out_if      out_mon,
  output int        fail_count,
  output int        pending_count
);
  import plist_pkg::*;

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] read_value;
    logic [4:0]         found_position;
    logic [4:0]         list_length;
  } list_result_t;

  logic signed [31:0] shadow [CAPACITY];
  int                 shadow_len;
  list_result_t       result_q[$];
  list_result_t       want;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    shadow_len    = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    fail_count++;
  endtask

  function automatic list_result_t apply_list_op(input mode_t m, input logic [4:0] p,
                                                 input logic signed [31:0] v);
    list_result_t r;
    int           pi;
    int           k;
    r        = '0;
    r.status = ST_OK;
    pi       = int'(p);
    case (m)
      MODE_INSERT: begin
        if (pi < 1 || pi > shadow_len + 1) begin
          r.status = ST_BADPOS;
        end else if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (k = shadow_len; k >= pi; k--) shadow[k] = shadow[k-1];
          shadow[pi-1] = v;
          shadow_len++;
        end
      end
      MODE_DELETE: begin
        if (pi < 1 || pi > shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.read_value = shadow[pi-1];
          for (k = pi; k < shadow_len; k++) shadow[k-1] = shadow[k];
          shadow_len--;
        end
      end
      MODE_GET: begin
        if (pi < 1 || pi > shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.read_value = shadow[pi-1];
        end
      end
      default: begin
        r.status = ST_NOTFOUND;
        for (k = 0; k < shadow_len; k++) begin
          if (r.status == ST_NOTFOUND && shadow[k] == v) begin
            r.found_position = 5'(k + 1);
            r.status         = ST_OK;
          end
        end
      end
    endcase
    r.list_length = 5'(shadow_len);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_len = 0;
      result_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = result_q.pop_front();
          if (out_mon.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_mon.status, want.status));
          if (out_mon.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got %0d want %0d",
                                      out_mon.read_value, want.read_value));
          if (out_mon.found_position !== want.found_position)
            report_mismatch($sformatf("found_position got %0d want %0d",
                                      out_mon.found_position, want.found_position));
          if (out_mon.list_length !== want.list_length)
            report_mismatch($sformatf("list_length got %0d want %0d",
                                      out_mon.list_length, want.list_length));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        result_q.push_back(apply_list_op(in_mon.mode, in_mon.position, in_mon.item_value));
      end
    end
    pending_count <= result_q.size();
  end

endmodule

>>> dv/positional_list_engine_top_tb.sv
`timescale 1ns / 1ps
module positional_list_engine_top_tb;
  import plist_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES  = 6;
  localparam int TAIL_CYCLES = 12;

  logic clk = 1'b0;
  logic rst_n;

  plist_in_if  in_chan ();
  plist_out_if out_chan ();

  int chk_fails;
  int chk_pending;

  positional_list_engine_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  plist_list_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (chk_fails),
    .pending_count (chk_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  int                 est_len = 0;
  bit                 tx_calm = 1'b0;
  bit                 rx_calm = 1'b0;
  int                 hold_seq = 0;
  int                 hold_seen = 0;
  int                 rx_stall = 0;
  int                 idle_cycles = 0;
  logic signed [31:0] val_pool [8];

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rx_stall = 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      rx_stall  = HOLD_CYCLES - 1;
      out_chan.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_chan.ready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      rx_stall = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("positional_list_engine_top_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return val_pool[$urandom_range(0, 7)];
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh0;
        1:       return -32'sd1;
        2:       return 32'sh7fffffff;
        default: return 32'sh80000000;
      endcase
    end
    return $urandom;
  endfunction

  task automatic track_length(input mode_t m, input logic [4:0] p);
    if (m == MODE_INSERT && p >= 1 && p <= est_len + 1 && est_len < CAPACITY) est_len++;
    else if (m == MODE_DELETE && p >= 1 && p <= est_len) est_len--;
  endtask

  task automatic send_req(input mode_t m, input logic [4:0] p, input logic signed [31:0] v);
    int gap;
    in_chan.valid      <= 1'b1;
    in_chan.mode       <= m;
    in_chan.position   <= p;
    in_chan.item_value <= v;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    track_length(m, p);
    if (tx_calm || $urandom_range(0, 99) < 45) gap = 0;
    else if ($urandom_range(0, 99) < 82) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
  endtask

  // bias: 0 mixed, 1 grow, 2 shrink
  task automatic send_random(input int bias);
    int         r;
    int         ins_w;
    int         del_w;
    mode_t      m;
    logic [4:0] p;
    ins_w = (bias == 1) ? 55 : (bias == 2) ? 15 : 30;
    del_w = (bias == 2) ? 55 : (bias == 1) ? 15 : 30;
    r = $urandom_range(0, 99);
    if (r < ins_w) m = MODE_INSERT;
    else if (r < ins_w + del_w) m = MODE_DELETE;
    else if (r[0]) m = MODE_GET;
    else m = MODE_LOCATE;
    if ($urandom_range(0, 9) == 0) p = 5'($urandom);
    else if (m == MODE_INSERT) p = 5'($urandom_range(1, est_len + 1));
    else if (est_len == 0) p = 5'd1;
    else p = 5'($urandom_range(1, est_len));
    send_req(m, p, pick_value());
  endtask

  initial begin
    in_chan.valid      <= 1'b0;
    in_chan.mode       <= MODE_INSERT;
    in_chan.position   <= 5'd0;
    in_chan.item_value <= 32'sd0;
    rst_n              <= 1'b0;
    foreach (val_pool[i]) val_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(MODE_GET,    5'd1,  32'sd0);
    send_req(MODE_DELETE, 5'd1,  32'sd0);
    send_req(MODE_LOCATE, 5'd0,  32'sd0);
    send_req(MODE_INSERT, 5'd0,  32'sd5);
    send_req(MODE_INSERT, 5'd2,  32'sd5);
    send_req(MODE_INSERT, 5'd1,  32'sh7fffffff);
    send_req(MODE_INSERT, 5'd1,  32'sh80000000);
    send_req(MODE_INSERT, 5'd3,  32'sd0);
    send_req(MODE_INSERT, 5'd2,  -32'sd1);
    send_req(MODE_GET,    5'd1,  32'sd0);
    send_req(MODE_GET,    5'd4,  32'sd0);
    send_req(MODE_LOCATE, 5'd31, -32'sd1);
    send_req(MODE_LOCATE, 5'd0,  32'sh12345678);
    send_req(MODE_INSERT, 5'd31, 32'sd7);
    send_req(MODE_DELETE, 5'd31, 32'sd0);
    send_req(MODE_GET,    5'd0,  32'sd0);
    send_req(MODE_DELETE, 5'd2,  32'sd0);
    send_req(MODE_DELETE, 5'd1,  32'sd0);
    send_req(MODE_DELETE, 5'(est_len), 32'sd0);
    send_req(MODE_INSERT, 5'd1,  val_pool[0]);
    send_req(MODE_LOCATE, 5'd0,  val_pool[0]);
    wait_results();

    // hold the result side while the list fills, then probe the full list
    tx_calm = 1'b1;
    hold_seq <= hold_seq + 1;
    while (est_len < CAPACITY)
      send_req(MODE_INSERT, 5'($urandom_range(1, est_len + 1)), val_pool[$urandom_range(0, 7)]);
    send_req(MODE_INSERT, 5'(CAPACITY + 1), 32'sd1);
    send_req(MODE_INSERT, 5'(CAPACITY + 2), 32'sd1);
    send_req(MODE_INSERT, 5'd1, 32'sd1);
    send_req(MODE_LOCATE, 5'd0, val_pool[1]);
    send_req(MODE_GET,    5'(CAPACITY), 32'sd0);
    send_req(MODE_DELETE, 5'(CAPACITY), 32'sd0);
    wait_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      tx_calm = (ph == 2);
      rx_calm <= (ph == 3);
      repeat (PHASE_ITEMS) send_random((ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 1 : 2);
      if (ph == 2) wait_results();
    end

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("positional_list_engine_top_tb OK");
    end else begin
      $display("positional_list_engine_top_tb NOT OK");
    end
    $finish;
  end

endmodule
